// ----- hw/rtl/windowed_grain_mixer_unit_macros.svh -----
// assertion helpers for the grain mixer checker
`ifndef WINDOWED_GRAIN_MIXER_UNIT_MACROS_SVH
`define WINDOWED_GRAIN_MIXER_UNIT_MACROS_SVH

// antecedent and consequent in the same cycle
`define GWM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define GWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gwm_pkg.sv -----
package gwm_pkg;

  localparam int unsigned BUF_LEN    = 32768;
  localparam int unsigned MAX_GRAINS = 256;

  localparam int unsigned ADDR_W = $clog2(BUF_LEN);
  localparam int unsigned SLOT_W = (MAX_GRAINS > 1) ? $clog2(MAX_GRAINS) : 1;
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned LEN_W  = 15;
  localparam int unsigned RCP_W  = 32;
  localparam int unsigned OUT_W  = 24;
  // each term is at most 2^15 in magnitude, summed over all slots
  localparam int unsigned ACC_W  = SMP_W + SLOT_W + 1;

  localparam logic [LEN_W-1:0] GRAIN_LEN_RESET = LEN_W'(4410);
  localparam logic [LEN_W-1:0] BLOCK_OFF_RESET = LEN_W'(64);
  // floor(2^31 / L) for the reset grain length
  localparam logic [RCP_W-1:0] RECIP_RESET =
    RCP_W'((64'd1 << 31) / 64'(GRAIN_LEN_RESET));

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  // register map
  localparam logic REG_GRAIN_LEN = 1'b0;
  localparam logic REG_BLOCK_OFF = 1'b1;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    trigger;
    logic [LEN_W-1:0]        start_offset;
  } gwm_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] mixed_sample;
    logic                    trigger_dropped;
  } gwm_out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] ridx;
    logic [LEN_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic [RCP_W-1:0]  recip;
  } gwm_slot_t;

  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } gwm_mul_req_t;

  typedef struct packed {
    logic             busy;
    logic [RCP_W-1:0] recip;
  } gwm_recip_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_FETCH,
    ST_MUL_WIN,
    ST_MUL_RECIP,
    ST_MUL_CHECK,
    ST_ACC,
    ST_DONE
  } gwm_state_e;

endpackage

// ----- hw/rtl/windowed_grain_mixer_unit.sv -----
// sequencing: an input transfer starts a sweep over every grain slot, and the result is
//   registered once the sweep is done; input is held off until the block is idle again
// throughput: one item per sweep, when the result is not stalled; an active grain costs a
//   fetch, three shared-multiplier steps and an accumulate; input waits on the reciprocal
// reset: async active low; control, grain activity and write index clear at once, the sample
//   store reads as zero at or above the fill mark, so no clearing pass is needed
module windowed_grain_mixer_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input items
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gwm_pkg::gwm_in_t in_data_i,
  // result items
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gwm_pkg::gwm_out_t out_data_o,
  // apb configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import gwm_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_GRAINS - 1);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic             cfg_wr;
  logic [LEN_W-1:0] grain_len_q;
  logic [LEN_W-1:0] block_off_q;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_BLOCK_OFF) ? {17'b0, block_off_q} : {17'b0, grain_len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grain_len_q <= GRAIN_LEN_RESET;
      block_off_q <= BLOCK_OFF_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_GRAIN_LEN) begin
        grain_len_q <= pwdata[LEN_W-1:0];
      end else begin
        block_off_q <= pwdata[LEN_W-1:0];
      end
    end
  end

  // reciprocal of the grain length, recomputed on every length write
  gwm_recip_t recip_stat;

  gwm_recip u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cfg_wr && (paddr[2] == REG_GRAIN_LEN)),
    .divisor_i(pwdata[LEN_W-1:0]),
    .stat_o   (recip_stat)
  );

  // ---------------------------------------------------------------------------
  // sequencer state
  // ---------------------------------------------------------------------------
  gwm_state_e        state_q, state_d;
  logic [SLOT_W-1:0] g_q, g_d;
  logic              in_xfer;
  logic              last_slot;
  logic              slot_act;
  logic              claim;

  logic [MAX_GRAINS-1:0] act_q;        // grain slot busy flags
  logic                  trig_pend_q;  // trigger still looking for a free slot
  logic [ADDR_W-1:0]     claim_ridx_q; // start address for a grain claimed this item
  logic [ADDR_W-1:0]     wr_idx_q;
  logic                  full_q;       // store written all the way round once

  assign in_ready_o = (state_q == ST_IDLE) && !recip_stat.busy;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign last_slot  = (g_q == LAST_SLOT);
  assign slot_act   = act_q[g_q];
  // the sweep runs from slot zero, so the first free slot it meets is the lowest
  assign claim      = (state_q == ST_SLOT) && !slot_act && trig_pend_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_SLOT;
        end
      end
      ST_SLOT: begin
        if (slot_act) begin
          state_d = ST_FETCH;
        end else if (trig_pend_q) begin
          state_d = ST_MUL_WIN;
        end else if (last_slot) begin
          state_d = ST_DONE;
        end
      end
      ST_FETCH:     state_d = ST_MUL_WIN;
      ST_MUL_WIN:   state_d = ST_MUL_RECIP;
      ST_MUL_RECIP: state_d = ST_MUL_CHECK;
      ST_MUL_CHECK: state_d = ST_ACC;
      ST_ACC: begin
        state_d = last_slot ? ST_DONE : ST_SLOT;
      end
      ST_DONE: begin
        if (!out_valid_o || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sample store: one write per item, one read per grain
  // ---------------------------------------------------------------------------
  logic [SMP_W-1:0]  smp_mem [BUF_LEN];
  logic [SMP_W-1:0]  smp_rdata_q;
  logic              smp_ok_q;
  logic              smp_re;
  logic [ADDR_W-1:0] smp_addr;

  // grain slot memory
  gwm_slot_t slot_mem [MAX_GRAINS];
  gwm_slot_t slot_rdata_q;
  gwm_slot_t slot_wdata;
  logic      slot_re;
  logic      slot_we;

  // working copy of the grain being mixed
  logic [ADDR_W-1:0]       w_ridx_q;
  logic [LEN_W-1:0]        w_pos_q;
  logic [LEN_W-1:0]        w_len_q;
  logic [RCP_W-1:0]        w_recip_q;
  logic                    s_neg_q;
  logic [30:0]             num_q;
  logic [SMP_W-1:0]        q0_q;
  logic signed [ACC_W-1:0] acc_q;

  // shared multiplier
  gwm_mul_req_t mul_req;
  logic [63:0]  prod;

  gwm_mul u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .prod_o(prod)
  );

  // window datapath
  logic signed [SMP_W-1:0] smp_val;
  logic [SMP_W-1:0]        smp_mag;
  logic                    rise_half;
  logic [LEN_W-1:0]        win_n;
  logic [LEN_W:0]          two_n;
  logic [30:0]             rem;
  logic                    bump;
  logic [SMP_W:0]          quot;
  logic signed [SMP_W+1:0] term;
  logic                    retire;

  // datapath controls, one per sequencer step
  always_comb begin
    slot_re  = (state_q == ST_SLOT) && slot_act;
    smp_re   = claim || (state_q == ST_FETCH);
    smp_addr = claim ? claim_ridx_q : slot_rdata_q.ridx;
    slot_we  = (state_q == ST_ACC);

    // zero where the store was never written since reset
    smp_val   = smp_ok_q ? $signed(smp_rdata_q) : '0;
    smp_mag   = smp_val[SMP_W-1] ? SMP_W'(~smp_rdata_q + 1'b1) : smp_val;
    rise_half = {w_pos_q, 1'b0} < {1'b0, w_len_q};
    win_n     = rise_half ? w_pos_q : LEN_W'(w_len_q - w_pos_q);
    two_n     = {win_n, 1'b0};

    // remainder check after the reciprocal estimate
    rem    = num_q - prod[30:0];
    bump   = rem >= 31'(w_len_q);
    quot   = {1'b0, q0_q} + (SMP_W+1)'(bump);
    term   = (w_len_q == '0) ? '0 :
             (s_neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot}));
    retire = (w_pos_q >= w_len_q);

    slot_wdata.ridx  = w_ridx_q + 1'b1;
    slot_wdata.pos   = w_pos_q + 1'b1;
    slot_wdata.len   = w_len_q;
    slot_wdata.recip = w_recip_q;

    mul_req = '0;
    case (state_q)
      ST_MUL_WIN: begin
        // |s| * 2n
        mul_req.en = 1'b1;
        mul_req.a  = {16'b0, smp_mag};
        mul_req.b  = {16'b0, two_n};
      end
      ST_MUL_RECIP: begin
        // quotient estimate from the latched reciprocal
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, prod[30:0]};
        mul_req.b  = w_recip_q;
      end
      ST_MUL_CHECK: begin
        // estimate times length, for the remainder
        mul_req.en = 1'b1;
        mul_req.a  = {16'b0, prod[46:31]};
        mul_req.b  = {17'b0, w_len_q};
      end
      default: mul_req = '0;
    endcase

    g_d = g_q;
    if (in_xfer) begin
      g_d = '0;
    end else if (((state_q == ST_SLOT) && !slot_act && !trig_pend_q) || (state_q == ST_ACC)) begin
      if (!last_slot) begin
        g_d = g_q + 1'b1;
      end
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      smp_mem[wr_idx_q] <= in_data_i.sample;
    end
    if (smp_re) begin
      smp_rdata_q <= smp_mem[smp_addr];
      smp_ok_q    <= full_q || (smp_addr < wr_idx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[g_q] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rdata_q <= slot_mem[g_q];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      g_q         <= '0;
      act_q       <= '0;
      trig_pend_q <= 1'b0;
      wr_idx_q    <= '0;
      full_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      g_q     <= g_d;
      if (in_xfer) begin
        wr_idx_q    <= wr_idx_q + 1'b1;
        trig_pend_q <= in_data_i.trigger;
        if (wr_idx_q == '1) begin
          full_q <= 1'b1;
        end
      end
      if (claim) begin
        act_q[g_q]  <= 1'b1;
        trig_pend_q <= 1'b0;
      end
      if ((state_q == ST_ACC) && retire) begin
        act_q[g_q] <= 1'b0;
      end
      // result register: a held result leaves on its transfer
      if ((state_q == ST_DONE) && (!out_valid_o || out_ready_i)) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      // start address uses the write index after this item's write
      claim_ridx_q <= in_data_i.start_offset + wr_idx_q + 1'b1 + block_off_q;
      acc_q        <= '0;
    end
    if (claim) begin
      w_ridx_q  <= claim_ridx_q;
      w_pos_q   <= '0;
      w_len_q   <= grain_len_q;
      w_recip_q <= recip_stat.recip;
    end else if (state_q == ST_FETCH) begin
      w_ridx_q  <= slot_rdata_q.ridx;
      w_pos_q   <= slot_rdata_q.pos;
      w_len_q   <= slot_rdata_q.len;
      w_recip_q <= slot_rdata_q.recip;
    end
    if (state_q == ST_MUL_WIN) begin
      s_neg_q <= smp_val[SMP_W-1];
    end
    if (state_q == ST_MUL_RECIP) begin
      num_q <= prod[30:0];
    end
    if (state_q == ST_MUL_CHECK) begin
      q0_q <= prod[46:31];
    end
    if (state_q == ST_ACC) begin
      acc_q <= acc_q + {{(ACC_W-SMP_W-2){term[SMP_W+1]}}, term};
    end
    if ((state_q == ST_DONE) && (!out_valid_o || out_ready_i)) begin
      // saturate the wide sum to the output range
      if (acc_q > SAT_HI) begin
        out_data_o.mixed_sample <= SAT_HI[OUT_W-1:0];
      end else if (acc_q < SAT_LO) begin
        out_data_o.mixed_sample <= SAT_LO[OUT_W-1:0];
      end else begin
        out_data_o.mixed_sample <= acc_q[OUT_W-1:0];
      end
      // trigger never claimed a slot in the whole sweep
      out_data_o.trigger_dropped <= trig_pend_q;
    end
  end

endmodule

// ----- hw/rtl/gwm_mul.sv -----
module gwm_mul (
  input  logic                  clk_i,
  input  gwm_pkg::gwm_mul_req_t req_i,
  output logic [63:0]           prod_o
);
  import gwm_pkg::*;

  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= req_i.a * req_i.b;
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- hw/rtl/gwm_recip.sv -----
module gwm_recip (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gwm_pkg::LEN_W-1:0] divisor_i,
  output gwm_pkg::gwm_recip_t       stat_o
);
  import gwm_pkg::*;

  // restoring division of 2^31 by the divisor, one quotient bit a cycle
  logic             busy_q, busy_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0] div_q, div_d;
  logic [RCP_W-1:0] quo_q, quo_d;
  logic [LEN_W:0]   shifted;
  logic             fits;

  always_comb begin
    shifted = {rem_q, (cnt_q == 5'd31)};
    fits    = shifted >= {1'b0, div_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    div_d   = div_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[RCP_W-2:0], fits};
      rem_d = fits ? LEN_W'(shifted - {1'b0, div_q}) : shifted[LEN_W-1:0];
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= RECIP_RESET;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      quo_q  <= quo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.recip = quo_q;

endmodule

// ----- hw/rtl/gwm_checker.sv -----
`include "windowed_grain_mixer_unit_macros.svh"

module gwm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input gwm_pkg::gwm_out_t out_data_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [2:0]        paddr
);
  import gwm_pkg::*;

  // an accepted item keeps the block busy for its sweep
  `GWM_ASSERT_NEXT(a_busy_after_xfer, in_valid_i && in_ready_o, !in_ready_o, "ready right after transfer")

  // a grain length write starts the reciprocal and holds off input
  `GWM_ASSERT_NEXT(a_busy_after_len_wr, psel && penable && pwrite && (paddr[2] == REG_GRAIN_LEN), !in_ready_o, "ready during reciprocal")

  // a stalled result holds
  `GWM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped or changed")

endmodule

bind windowed_grain_mixer_unit gwm_checker u_gwm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr)
);

// ----- test/windowed_grain_mixer_unit_tb.sv -----
module windowed_grain_mixer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gwm_pkg::*;

  // receiver hold-off long enough to fill the block several sweeps over
  localparam int LONG_HOLD = 2000;
  // cycles without any transfer before the run is declared hung
  localparam int WATCHDOG_LIMIT = 20000;
  // quiet time after the last result, one full sweep with every slot busy
  localparam int DRAIN_CYCLES = 1600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  gwm_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  gwm_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  windowed_grain_mixer_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // mixer model: sample store, write pointer, grain slots and the two settings
  // ---------------------------------------------------------------------------
  bit [SMP_W-1:0] smp_store [BUF_LEN];
  int unsigned    wr_ptr;
  bit             grain_live [MAX_GRAINS];
  int unsigned    grain_ridx [MAX_GRAINS];
  int unsigned    grain_step [MAX_GRAINS];
  int unsigned    grain_len  [MAX_GRAINS];
  int unsigned    cfg_grain_len = GRAIN_LEN_RESET;
  int unsigned    cfg_block_off = BLOCK_OFF_RESET;

  gwm_in_t  sample_fifo [$];  // items waiting to be offered
  gwm_out_t pending_mix [$];  // predicted results, oldest first
  int       items_queued;
  int       items_taken;
  int       errors;

  bit quiet;     // no idling on either side
  bit hold_req;  // asks the receiver for one long hold-off

  // one audio step: store the sample, maybe start a grain, sum all windowed grains
  function automatic gwm_out_t predict_mix(input gwm_in_t it);
    gwm_out_t    res;
    longint      acc;
    longint      smp;
    int unsigned slot;
    int unsigned p;
    int unsigned n;
    int unsigned len;
    bit          found;
    int          g;
    res   = '0;
    acc   = 0;
    found = 1'b0;
    slot  = 0;
    smp_store[wr_ptr] = it.sample;
    wr_ptr = (wr_ptr + 1) % BUF_LEN;
    if (it.trigger) begin
      // lowest free slot wins
      for (g = 0; g < MAX_GRAINS; g++) begin
        if (!found && !grain_live[g]) begin
          slot  = g;
          found = 1'b1;
        end
      end
      if (!found) begin
        res.trigger_dropped = 1'b1;
      end else begin
        // start point uses the pointer after this step's write
        grain_ridx[slot] = (it.start_offset + wr_ptr + cfg_block_off) % BUF_LEN;
        grain_step[slot] = 0;
        grain_len[slot]  = cfg_grain_len;
        grain_live[slot] = 1'b1;
      end
    end
    for (g = 0; g < MAX_GRAINS; g++) begin
      if (grain_live[g]) begin
        p   = grain_step[g];
        len = grain_len[g];
        smp = longint'($signed(smp_store[grain_ridx[g]]));
        // triangle: rising half up to L/2, falling back to zero at p = L
        if (len != 0) begin
          n = (2 * p < len) ? p : len - p;
          acc += (smp * 2 * longint'(n)) / longint'(len);
        end
        if (p >= len) begin
          grain_live[g] = 1'b0;
        end else begin
          grain_ridx[g] = (grain_ridx[g] + 1) % BUF_LEN;
          grain_step[g] = p + 1;
        end
      end
    end
    if (acc > 64'sd8388607) acc = 64'sd8388607;
    if (acc < -64'sd8388608) acc = -64'sd8388608;
    res.mixed_sample = acc[OUT_W-1:0];
    return res;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // input driver: offers queued items, idles in bursts between transfers
  // ---------------------------------------------------------------------------
  int tx_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tx_gap > 0) begin
        tx_gap   <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (sample_fifo.size() > 0 && !quiet && $urandom_range(0, 11) == 0) begin
        // burst of 1 to 10 idle cycles, this one included
        tx_gap   <= $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (sample_fifo.size() > 0) begin
        in_data  <= sample_fifo.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stall bursts plus one long hold-off on request
  // ---------------------------------------------------------------------------
  int rx_gap;
  int hold_left;
  bit hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= LONG_HOLD - 1;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap    <= rx_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      rx_gap    <= $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each input transfer, compare on each result transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    gwm_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_mix.push_back(predict_mix(in_data));
        items_taken++;
      end
      if (out_valid && out_ready) begin
        if (pending_mix.size() == 0) begin
          flag_error($sformatf("result with nothing pending: mixed_sample %0d dropped %0b",
                               out_data.mixed_sample, out_data.trigger_dropped));
        end else begin
          want = pending_mix.pop_front();
          if (out_data.mixed_sample !== want.mixed_sample)
            flag_error($sformatf("mixed_sample: expected %0d, got %0d",
                                 want.mixed_sample, out_data.mixed_sample));
          if (out_data.trigger_dropped !== want.trigger_dropped)
            flag_error($sformatf("trigger_dropped: expected %0b, got %0b",
                                 want.trigger_dropped, out_data.trigger_dropped));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: any transfer or register access counts as progress
  // ---------------------------------------------------------------------------
  int idle_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input gwm_in_t it);
    sample_fifo.push_back(it);
    items_queued++;
  endtask

  // random item; most grains are aimed a short lag behind the newest sample
  // so that they read audio actually written rather than the cleared store
  function automatic gwm_in_t grain_item(input bit trig);
    gwm_in_t     it;
    int unsigned lag;
    lag = $urandom_range(0, (items_queued < 300) ? items_queued : 300);
    it.sample = SMP_W'($urandom);
    if ($urandom_range(0, 9) == 0) it.sample = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    it.trigger = trig;
    if ($urandom_range(0, 4) == 0)
      it.start_offset = LEN_W'($urandom);
    else
      it.start_offset = LEN_W'(2 * BUF_LEN - 1 - lag - cfg_block_off);
    return it;
  endfunction

  // block idle: every offered item taken and every result back
  task automatic wait_idle;
    while (items_taken != items_queued || pending_mix.size() != 0) @(posedge clk);
  endtask

  // apb write, then read back; the model follows the write
  task automatic write_reg(input logic idx, input int unsigned val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // register takes the value at this edge; go straight into the read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {17'b0, val[LEN_W-1:0]})
      flag_error($sformatf("register %0d readback: expected %0d, got %0d", idx, val, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_GRAIN_LEN) cfg_grain_len = val[LEN_W-1:0];
    else cfg_block_off = val[LEN_W-1:0];
  endtask

  // settings change between phases, then a batch of random items
  task automatic run_phase(input int unsigned len, input int unsigned boff, input int n,
                           input int unsigned trig_odds);
    wait_idle();
    write_reg(REG_GRAIN_LEN, len);
    write_reg(REG_BLOCK_OFF, boff);
    repeat (n) queue_item(grain_item($urandom_range(1, trig_odds) == 1));
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: sample and offset extremes, grains at the reset length
    queue_item({16'h7fff, 1'b0, 15'h0000});
    queue_item({16'h8000, 1'b0, 15'h7fff});
    queue_item({16'h0000, 1'b0, 15'h2aaa});
    queue_item({16'hffff, 1'b0, 15'h5555});
    queue_item(grain_item(1'b1));
    repeat (5) queue_item(grain_item(1'b0));
    queue_item({16'h8000, 1'b1, 15'h7fff});  // trigger at the largest offset
    repeat (4) queue_item(grain_item(1'b0));

    // shortest legal grain and smallest offset, then the zero-length case
    run_phase(1, 0, 10, 2);
    run_phase(0, 0, 10, 2);
    run_phase(2, 0, 10, 2);

    // every item triggers with grains outliving the slot count: slots fill up,
    // triggers get dropped, then retired slots are reclaimed
    run_phase(260, 32767, 275, 1);

    // mid-length grains; receiver holds off while items keep coming
    run_phase($urandom_range(2, 150), $urandom_range(0, 32767), 210, 3);
    hold_req = 1'b1;

    run_phase($urandom_range(1, 30), $urandom_range(0, 32767), 210, 2);

    // last part without idling: longest grains, which wrap around the store
    wait_idle();
    quiet = 1'b1;
    run_phase(32767, 32767, 60, 20);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
